// File: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an expression at every rising edge, also while reset is held.
`define ASSERT_AT_EDGE(label, clk, expr, msg) \
    label: assert property (@(posedge clk) (expr)) else $error(msg);

// Checks an expression at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/gste_pkg.sv
// Shared types, constants and helper functions of the GPS sentence time extractor.
`default_nettype none

package gste_pkg;

    // Characters that steer the parser.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_UPPER_G = 8'h47;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    // Field numbers inside the sentence body.
    localparam logic [3:0] FIELD_IDENT  = 4'd0;
    localparam logic [3:0] FIELD_TIME   = 4'd1;
    localparam logic [3:0] FIELD_STATUS = 4'd2;
    localparam logic [3:0] FIELD_MAX    = 4'd15;
    localparam logic [2:0] COUNT_MAX    = 3'd7;
    localparam int         TIME_DIGITS  = 6;

    // Widths of the register and the result fields.
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;

    // Reset value of the hour offset register.
    localparam logic [HOUR_W-1:0] HOUR_OFFSET_RESET = 5'd8;

    // Default depth of the record queue between parser and formatter.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // One finished sentence as seen by the parser.
    typedef struct packed {
        logic        checksum_ok;
        logic        status_a;
        logic        ident_g;
        logic [23:0] time_digits;
    } rec_t;

    // Decoded hex character.
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // Accepts 0-9, A-F and a-f.
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.val = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.val = 4'(c - 8'h57);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Two BCD digits to a binary value of at most 99.
    function automatic logic [6:0] two_digits(input logic [3:0] tens,
                                              input logic [3:0] units);
        logic [6:0] t;
        t = {3'd0, tens};
        return (t << 3) + (t << 1) + {3'd0, units};
    endfunction

endpackage

`default_nettype wire

// File: design/gps_sentence_time_extractor.sv
// Top level of the GPS sentence time extractor.
//
// Characters enter through a queue-style port: an item is taken at a rising edge
// with push high and full low; full is high only while the record queue between
// the parser and the formatter holds QUEUE_DEPTH finished sentences.
// One character is taken every cycle while full is low; the parser updates its
// field and checksum state in that same cycle.
// The second checksum digit of a sentence makes a record that enters the queue at
// the edge that takes that character and moves on to the output register when
// it heads the queue and that register is free (empty falls then).
// Results leave through empty/pop; a result waits in the output register until
// popped, while up to QUEUE_DEPTH more sentences collect behind it and
// characters keep flowing until that queue is full.
// The hour offset register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high and the write takes effect on the next edge.
// Reset clears the parser (no sentence open), empties the queue and the output
// register, and sets the hour offset to 8.
`default_nettype none

module gps_sentence_time_extractor #(
    parameter int QUEUE_DEPTH = gste_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [7:0]                  char_code,
    output logic                             empty,
    input  wire logic                        pop,
    output logic                             sentence_ok,
    output logic                             checksum_ok,
    output logic                             status_active,
    output logic [gste_pkg::HOUR_W-1:0]      local_hour,
    output logic [gste_pkg::MIN_W-1:0]       minute,
    output logic [gste_pkg::SEC_W-1:0]       second,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [gste_pkg::HOUR_W-1:0] cfg_data
);
    import gste_pkg::*;

    logic rec_push, rec_pop, q_full, q_empty;
    rec_t rec_in, rec_out;

    assign full      = q_full;
    assign cfg_ready = 1'b1;

    // Parser.
    gste_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (push && !q_full),
        .char_code (char_code),
        .rec_push  (rec_push),
        .rec       (rec_in)
    );

    // Record queue.
    gste_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec_in),
        .full    (q_full),
        .rd_en   (rec_pop),
        .rd_data (rec_out),
        .empty   (q_empty)
    );

    // Formatter and output register.
    gste_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .rec_valid     (!q_empty),
        .rec           (rec_out),
        .rec_pop       (rec_pop),
        .pop           (pop),
        .empty         (empty),
        .sentence_ok   (sentence_ok),
        .checksum_ok   (checksum_ok),
        .status_active (status_active),
        .local_hour    (local_hour),
        .minute        (minute),
        .second        (second)
    );

endmodule

`default_nettype wire

// File: design/gste_front.sv
// Character parser: tracks fields and checksum, and hands out one record per sentence.
`default_nettype none

module gste_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     char_code,
    output logic                rec_push,
    output gste_pkg::rec_t      rec
);
    import gste_pkg::*;

    typedef enum logic [1:0] {HP_BODY, HP_FIRST, HP_SECOND} hex_phase_t;

    logic        in_sentence_reg, in_sentence_next;
    logic [7:0]  checksum_acc_reg, checksum_acc_next;
    logic [3:0]  field_number_reg, field_number_next;
    logic [2:0]  field_count_reg, field_count_next;
    logic        ident_g_reg, ident_g_next;
    logic [23:0] time_digits_reg, time_digits_next;
    logic        status_a_reg, status_a_next;
    hex_phase_t  hex_phase_reg, hex_phase_next;
    logic [7:0]  rx_checksum_reg, rx_checksum_next;

    hex_t        hx;
    logic [3:0]  digit;
    logic [7:0]  rx_full;

    assign hx      = hex_decode(char_code);
    assign digit   = (char_code >= 8'h30 && char_code <= 8'h39) ? 4'(char_code - 8'h30) : 4'd0;
    assign rx_full = {rx_checksum_reg[3:0], hx.val};

    // Next state of the parser for the accepted item.
    always_comb
    begin
        in_sentence_next  = in_sentence_reg;
        checksum_acc_next = checksum_acc_reg;
        field_number_next = field_number_reg;
        field_count_next  = field_count_reg;
        ident_g_next      = ident_g_reg;
        time_digits_next  = time_digits_reg;
        status_a_next     = status_a_reg;
        hex_phase_next    = hex_phase_reg;
        rx_checksum_next  = rx_checksum_reg;
        rec_push          = 1'b0;

        if (accept)
        begin
            if (char_code == CHAR_DOLLAR)
            begin
                in_sentence_next  = 1'b1;
                checksum_acc_next = 8'd0;
                field_number_next = FIELD_IDENT;
                field_count_next  = 3'd0;
                ident_g_next      = 1'b0;
                time_digits_next  = 24'd0;
                status_a_next     = 1'b0;
                hex_phase_next    = HP_BODY;
                rx_checksum_next  = 8'd0;
            end
            else if (in_sentence_reg)
            begin
                if (hex_phase_reg == HP_BODY)
                begin
                    if (char_code == CHAR_STAR)
                    begin
                        hex_phase_next = HP_FIRST;
                    end
                    else
                    begin
                        checksum_acc_next = checksum_acc_reg ^ char_code;
                        if (char_code == CHAR_COMMA)
                        begin
                            if (field_number_reg != FIELD_MAX)
                            begin
                                field_number_next = field_number_reg + 4'd1;
                            end
                            field_count_next = 3'd0;
                        end
                        else
                        begin
                            if (field_number_reg == FIELD_IDENT && field_count_reg == 3'd0)
                            begin
                                ident_g_next = (char_code == CHAR_UPPER_G);
                            end
                            else if (field_number_reg == FIELD_TIME)
                            begin
                                // Only the first six characters land in a digit slot.
                                for (int i = 0; i < TIME_DIGITS; i++)
                                begin
                                    if (field_count_reg == 3'(i))
                                    begin
                                        time_digits_next[23-4*i -: 4] = digit;
                                    end
                                end
                            end
                            else if (field_number_reg == FIELD_STATUS)
                            begin
                                status_a_next = (field_count_reg == 3'd0) &&
                                                (char_code == CHAR_UPPER_A);
                            end
                            if (field_count_reg != COUNT_MAX)
                            begin
                                field_count_next = field_count_reg + 3'd1;
                            end
                        end
                    end
                end
                else if (!hx.ok)
                begin
                    // A bad checksum digit drops the sentence.
                    in_sentence_next = 1'b0;
                    hex_phase_next   = HP_BODY;
                end
                else
                begin
                    rx_checksum_next = rx_full;
                    if (hex_phase_reg == HP_FIRST)
                    begin
                        hex_phase_next = HP_SECOND;
                    end
                    else
                    begin
                        in_sentence_next = 1'b0;
                        hex_phase_next   = HP_BODY;
                        rec_push         = 1'b1;
                    end
                end
            end
        end
    end

    // Record of the sentence that completes with this item.
    always_comb
    begin
        rec.checksum_ok = (rx_full == checksum_acc_reg);
        rec.status_a    = status_a_reg;
        rec.ident_g     = ident_g_reg;
        rec.time_digits = time_digits_reg;
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg  <= 1'b0;
            checksum_acc_reg <= 8'd0;
            field_number_reg <= FIELD_IDENT;
            field_count_reg  <= 3'd0;
            ident_g_reg      <= 1'b0;
            time_digits_reg  <= 24'd0;
            status_a_reg     <= 1'b0;
            hex_phase_reg    <= HP_BODY;
            rx_checksum_reg  <= 8'd0;
        end
        else
        begin
            in_sentence_reg  <= in_sentence_next;
            checksum_acc_reg <= checksum_acc_next;
            field_number_reg <= field_number_next;
            field_count_reg  <= field_count_next;
            ident_g_reg      <= ident_g_next;
            time_digits_reg  <= time_digits_next;
            status_a_reg     <= status_a_next;
            hex_phase_reg    <= hex_phase_next;
            rx_checksum_reg  <= rx_checksum_next;
        end
    end

endmodule

`default_nettype wire

// File: design/gste_queue.sv
// Short record queue between the parser and the result formatter.
`default_nettype none

module gste_queue #(
    parameter int DEPTH = gste_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  gste_pkg::rec_t      wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output gste_pkg::rec_t      rd_data,
    output logic                empty
);
    import gste_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    rec_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: design/gste_back.sv
// Result formatter: converts a record to local time and holds it in the output register.
`default_nettype none

module gste_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [gste_pkg::HOUR_W-1:0] cfg_data,
    input  wire logic                       rec_valid,
    input  gste_pkg::rec_t                  rec,
    output logic                            rec_pop,
    input  wire logic                       pop,
    output logic                            empty,
    output logic                            sentence_ok,
    output logic                            checksum_ok,
    output logic                            status_active,
    output logic [gste_pkg::HOUR_W-1:0]     local_hour,
    output logic [gste_pkg::MIN_W-1:0]      minute,
    output logic [gste_pkg::SEC_W-1:0]      second
);
    import gste_pkg::*;

    logic              out_valid_reg;
    logic [HOUR_W-1:0] hour_offset_reg;
    logic              ok_reg, ck_reg, st_reg;
    logic [HOUR_W-1:0] hour_reg, hour_next;
    logic [MIN_W-1:0]  minute_reg, minute_next;
    logic [SEC_W-1:0]  second_reg, second_next;

    logic [7:0]        hr_sum, hr_m96, hr_m48;
    logic [6:0]        mi_raw, se_raw;
    logic              load;

    assign load    = rec_valid && (!out_valid_reg || pop);
    assign rec_pop = load;

    // Hour plus offset, brought below 24 by three conditional subtractions.
    always_comb
    begin
        hr_sum = {1'b0, two_digits(rec.time_digits[23:20], rec.time_digits[19:16])}
                 + {3'd0, hour_offset_reg};
        hr_m96 = (hr_sum >= 8'd96) ? hr_sum - 8'd96 : hr_sum;
        hr_m48 = (hr_m96 >= 8'd48) ? hr_m96 - 8'd48 : hr_m96;
        hour_next = (hr_m48 >= 8'd24) ? HOUR_W'(hr_m48 - 8'd24) : HOUR_W'(hr_m48);
    end

    // Minutes and seconds, saturated at 59.
    always_comb
    begin
        mi_raw = two_digits(rec.time_digits[15:12], rec.time_digits[11:8]);
        se_raw = two_digits(rec.time_digits[7:4], rec.time_digits[3:0]);
        minute_next = (mi_raw > 7'd59) ? MIN_W'(59) : MIN_W'(mi_raw);
        second_next = (se_raw > 7'd59) ? SEC_W'(59) : SEC_W'(se_raw);
    end

    // Offset register and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_offset_reg <= HOUR_OFFSET_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hour_offset_reg <= cfg_data;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg     <= rec.checksum_ok && rec.status_a && rec.ident_g;
            ck_reg     <= rec.checksum_ok;
            st_reg     <= rec.status_a;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    assign empty         = !out_valid_reg;
    assign sentence_ok   = ok_reg;
    assign checksum_ok   = ck_reg;
    assign status_active = st_reg;
    assign local_hour    = hour_reg;
    assign minute        = minute_reg;
    assign second        = second_reg;

endmodule

`default_nettype wire

// File: design/gste_checker.sv
// Port-level checker of the GPS sentence time extractor and its bind.
`default_nettype none
`include "assert_macros.svh"

module gste_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        full,
    input wire logic                        empty,
    input wire logic                        pop,
    input wire logic                        sentence_ok,
    input wire logic                        checksum_ok,
    input wire logic                        status_active,
    input wire logic [gste_pkg::HOUR_W-1:0] local_hour,
    input wire logic [gste_pkg::MIN_W-1:0]  minute,
    input wire logic [gste_pkg::SEC_W-1:0]  second
);
    logic time_in_range;
    logic ok_has_parts;
    logic [gste_pkg::HOUR_W+gste_pkg::MIN_W+gste_pkg::SEC_W+2:0] payload;

    // Derived terms that keep the assertions short.
    assign time_in_range = (minute <= 6'd59) && (second <= 6'd59);
    assign ok_has_parts  = !sentence_ok || (checksum_ok && status_active);
    assign payload       = {sentence_ok, checksum_ok, status_active, local_hour, minute, second};

    // Reset leaves no result and room for input.
    `ASSERT_AT_EDGE(a_reset_idle, clk, rst_n || (empty && !full), "result or full during reset")

    // The hour is always reduced below 24.
    `ASSERT_ALWAYS(a_hour_range, clk, rst_n, empty || (local_hour < 5'd24), "hour out of range")

    // Minutes and seconds are saturated at 59.
    `ASSERT_ALWAYS(a_min_sec_range, clk, rst_n, empty || time_in_range, "minute or second above 59")

    // A good sentence needs a matching checksum and an active status.
    `ASSERT_ALWAYS(a_ok_parts, clk, rst_n, empty || ok_has_parts, "sentence_ok without its parts")

    // A result that is not popped stays and keeps its value.
    `ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(payload), "waiting result changed")

endmodule

bind gps_sentence_time_extractor gste_checker u_gste_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .sentence_ok   (sentence_ok),
    .checksum_ok   (checksum_ok),
    .status_active (status_active),
    .local_hour    (local_hour),
    .minute        (minute),
    .second        (second)
);

`default_nettype wire

// File: tb/sv/gps_sentence_time_extractor_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the GPS sentence time extractor.
module gps_sentence_time_extractor_tb;
    import gste_pkg::*;

    // Generous cycle budget for the whole run.
    localparam int CLOCK_LIMIT = 400000;

    // Receiver stall patterns.
    typedef enum {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_BURSTY} pop_mode_t;

    // Letter case of the checksum digits sent after the star.
    typedef enum {HEX_UPPER, HEX_LOWER, HEX_MIXED} hex_case_t;

    // One expected time fix.
    typedef struct packed {
        logic              sentence_ok;
        logic              checksum_ok;
        logic              status_active;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } time_fix_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b1;
    logic              push = 1'b0;
    logic [7:0]        char_code = 8'h00;
    logic              pop = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [HOUR_W-1:0] cfg_data = '0;
    logic              full;
    logic              empty;
    logic              sentence_ok;
    logic              checksum_ok;
    logic              status_active;
    logic [HOUR_W-1:0] local_hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              cfg_ready;

    // Characters waiting to be sent and fixes waiting to come out.
    logic [7:0] pending_chars[$];
    time_fix_t  expected_fixes[$];
    int         queued_chars = 0;
    int         error_count = 0;

    // Parser state mirrored by the testbench.
    logic              open_sentence = 1'b0;
    logic [7:0]        running_xor = 8'h00;
    logic [3:0]        field_idx = 4'd0;
    logic [2:0]        field_len = 3'd0;
    logic              talker_g = 1'b0;
    logic [23:0]       hhmmss = 24'h0;
    logic              status_a = 1'b0;
    logic [1:0]        star_phase = 2'd0;
    logic [7:0]        sum_digits = 8'h00;
    logic [HOUR_W-1:0] offset_hours = HOUR_OFFSET_RESET;

    // Sender and receiver pacing.
    int        burst_left = 1;
    int        gap_left = 0;
    int        stall_tick = 0;
    pop_mode_t stall_mode = POP_ALWAYS;

    gps_sentence_time_extractor DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_code     (char_code),
        .empty         (empty),
        .pop           (pop),
        .sentence_ok   (sentence_ok),
        .checksum_ok   (checksum_ok),
        .status_active (status_active),
        .local_hour    (local_hour),
        .minute        (minute),
        .second        (second),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Clock generation.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Decodes one checksum digit; returns 0 when the character is not hex.
    function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9")
            v = 4'(c - "0");
        else if (c >= "A" && c <= "F")
            v = 4'(c - "A" + 10);
        else if (c >= "a" && c <= "f")
            v = 4'(c - "a" + 10);
        else
            return 1'b0;
        return 1'b1;
    endfunction

    // Updates the mirrored parser with one accepted character.
    task automatic parse_char(input logic [7:0] c);
        logic [3:0] nibble;
        int         hh;
        int         mm;
        int         ss;
        time_fix_t  fix;
        if (c == CHAR_DOLLAR)
        begin
            open_sentence = 1'b1;
            running_xor   = 8'h00;
            field_idx     = 4'd0;
            field_len     = 3'd0;
            talker_g      = 1'b0;
            hhmmss        = 24'h0;
            status_a      = 1'b0;
            star_phase    = 2'd0;
            sum_digits    = 8'h00;
            return;
        end
        if (!open_sentence)
            return;

        // Body characters: checksum, field split and field capture.
        if (star_phase == 2'd0)
        begin
            if (c == CHAR_STAR)
            begin
                star_phase = 2'd1;
                return;
            end
            running_xor ^= c;
            if (c == CHAR_COMMA)
            begin
                if (field_idx != FIELD_MAX)
                    field_idx++;
                field_len = 3'd0;
                return;
            end
            if (field_idx == FIELD_IDENT && field_len == 3'd0)
                talker_g = (c == CHAR_UPPER_G);
            else if (field_idx == FIELD_TIME && field_len < TIME_DIGITS)
                hhmmss[23 - 4 * field_len -: 4] = (c >= "0" && c <= "9") ? 4'(c - "0") : 4'd0;
            else if (field_idx == FIELD_STATUS)
                status_a = (field_len == 3'd0) && (c == CHAR_UPPER_A);
            if (field_len != COUNT_MAX)
                field_len++;
            return;
        end

        // Checksum digits after the star.
        if (!hex_value(c, nibble))
        begin
            open_sentence = 1'b0;
            star_phase    = 2'd0;
            return;
        end
        sum_digits = {sum_digits[3:0], nibble};
        if (star_phase == 2'd1)
        begin
            star_phase = 2'd2;
            return;
        end
        open_sentence = 1'b0;
        star_phase    = 2'd0;
        hh = 10 * hhmmss[23:20] + hhmmss[19:16];
        mm = 10 * hhmmss[15:12] + hhmmss[11:8];
        ss = 10 * hhmmss[7:4] + hhmmss[3:0];
        fix.checksum_ok   = (sum_digits == running_xor);
        fix.status_active = status_a;
        fix.sentence_ok   = fix.checksum_ok && status_a && talker_g;
        fix.hour          = HOUR_W'((hh + offset_hours) % 24);
        fix.minute        = MIN_W'((mm > 59) ? 59 : mm);
        fix.second        = SEC_W'((ss > 59) ? 59 : ss);
        expected_fixes.push_back(fix);
    endtask

    // Reports one field mismatch.
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n || pending_chars.size() == 0 || gap_left != 0)
        begin
            push <= 1'b0;
            if (gap_left != 0)
                gap_left--;
        end
        else
        begin
            push      <= 1'b1;
            char_code <= pending_chars[0];
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
            else
                burst_left--;
        end
    end

    // Accepted characters feed the mirrored parser.
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            parse_char(char_code);
            void'(pending_chars.pop_front());
        end
    end

    // Receiver: pops according to a stall pattern that is redrawn at random.
    always @(negedge clk)
    begin
        stall_tick++;
        if (stall_tick % 97 == 0)
            stall_mode = pop_mode_t'($urandom_range(0, 3));
        case (stall_mode)
            POP_ALWAYS: pop <= 1'b1;
            POP_COIN:   pop <= 1'($urandom_range(0, 1));
            POP_SPARSE: pop <= (stall_tick % 4 == 0);
            default:    pop <= (stall_tick % 32 >= 30);
        endcase
    end

    // Each popped fix is checked against the oldest expectation.
    always @(posedge clk)
    begin : fix_check
        time_fix_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_fixes.size() == 0)
            begin
                $error("time fix popped with no sentence outstanding");
                error_count++;
            end
            else
            begin
                want = expected_fixes.pop_front();
                check_field("sentence_ok", want.sentence_ok, sentence_ok);
                check_field("checksum_ok", want.checksum_ok, checksum_ok);
                check_field("status_active", want.status_active, status_active);
                check_field("local_hour", want.hour, local_hour);
                check_field("minute", want.minute, minute);
                check_field("second", want.second, second);
            end
        end
    end

    // Watchdog.
    initial
    begin
        repeat (CLOCK_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] c);
        pending_chars.push_back(c);
        queued_chars++;
    endtask

    task automatic send_raw(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Any byte that neither opens, ends nor splits a sentence.
    function automatic logic [7:0] random_body_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CHAR_DOLLAR || c == CHAR_STAR || c == CHAR_COMMA);
        return c;
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        logic [3:0] v;
        do
            c = 8'($urandom_range(0, 255));
        while (hex_value(c, v));
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10)
            return "0" + n;
        return 8'((lower ? "a" : "A") + n - 10);
    endfunction

    // Sends a framed sentence with a correct or a corrupted checksum.
    task automatic send_sentence(input logic [7:0] body[$], input bit sum_good,
                                 input hex_case_t hcase);
        logic [7:0] sum;
        sum = 8'h00;
        send_byte(CHAR_DOLLAR);
        foreach (body[i])
        begin
            send_byte(body[i]);
            sum ^= body[i];
        end
        if (!sum_good)
            sum ^= 8'($urandom_range(1, 255));
        send_byte(CHAR_STAR);
        for (int k = 1; k >= 0; k--)
            send_byte(hex_char(sum[4 * k +: 4],
                               hcase == HEX_LOWER ||
                               (hcase == HEX_MIXED && $urandom_range(0, 1) == 1)));
    endtask

    task automatic send_text(input string s, input bit sum_good, input hex_case_t hcase);
        logic [7:0] body[$];
        for (int i = 0; i < s.len(); i++)
            body.push_back(s[i]);
        send_sentence(body, sum_good, hcase);
    endtask

    // Builds one random sentence; most are well formed, some broken or noise.
    task automatic send_random_sentence(output bit makes_result);
        logic [7:0] body[$];
        int         fields;
        int         len;
        int         pick;
        makes_result = 1'b0;
        fields = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 3;

        // Identifier, mostly with a G talker.
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++)
        begin
            if (i == 0 && $urandom_range(0, 9) < 7)
                body.push_back(CHAR_UPPER_G);
            else if ($urandom_range(0, 4) != 0)
                body.push_back(8'("A" + $urandom_range(0, 25)));
            else
                body.push_back(random_body_byte());
        end

        // Time field, usually six digits.
        if (fields > 1)
        begin
            body.push_back(CHAR_COMMA);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : TIME_DIGITS;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) != 0)
                    body.push_back(8'("0" + $urandom_range(0, 9)));
                else
                    body.push_back(random_body_byte());
            end
        end

        // Status field, then a few trailing fields, now and then enough to saturate.
        if (fields > 2)
        begin
            body.push_back(CHAR_COMMA);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                body.push_back(CHAR_UPPER_A);
            else if (pick == 6)
                body.push_back("V");
            else if (pick == 8)
            begin
                body.push_back(CHAR_UPPER_A);
                body.push_back(random_body_byte());
            end
            else if (pick == 9)
                repeat ($urandom_range(1, 3)) body.push_back(random_body_byte());
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 3))
            begin
                body.push_back(CHAR_COMMA);
                repeat ($urandom_range(0, 8)) body.push_back(random_body_byte());
            end
        end

        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            // A non-hex character after the star drops the sentence.
            send_byte(CHAR_DOLLAR);
            foreach (body[i])
                send_byte(body[i]);
            send_byte(CHAR_STAR);
            if ($urandom_range(0, 1) == 1)
                send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            send_byte(random_non_hex());
        end
        else if (pick == 1)
        begin
            // Cut short; the next dollar restarts the sentence.
            len = $urandom_range(0, body.size());
            send_byte(CHAR_DOLLAR);
            for (int i = 0; i < len; i++)
                send_byte(body[i]);
        end
        else if (pick == 2)
        begin
            // Line noise.
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            send_sentence(body, $urandom_range(0, 7) != 0, HEX_MIXED);
            makes_result = 1'b1;
        end
    endtask

    // Writes the hour offset; only called while the block is idle.
    task automatic write_offset(input logic [HOUR_W-1:0] hours);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= hours;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        offset_hours = hours;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every character is sent and every fix has come out.
    task automatic wait_idle();
        while (pending_chars.size() != 0 || expected_fixes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_phase(input int char_goal, input int fix_goal);
        int start;
        int made;
        bit got;
        start = queued_chars;
        made  = 0;
        while (queued_chars - start < char_goal || made < fix_goal)
        begin
            send_random_sentence(got);
            made += got;
        end
        wait_idle();
    endtask

    // Main sequence.
    initial
    begin
        // Reset goes active before the first edge so every register with a reset starts known.
        #1 rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed sentences with the reset offset.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_raw("noise*,A");
        send_text("GPRMC,123519,A,4807.038,N", 1'b1, HEX_UPPER);
        send_text("GPGGA,235959,A", 1'b1, HEX_LOWER);
        send_text("GNRMC,000000,V", 1'b1, HEX_MIXED);
        send_text("GPRMC,12,A", 1'b1, HEX_UPPER);
        send_text("GPRMC,1x3:5!,A", 1'b1, HEX_UPPER);
        send_text("GPRMC,997799,A", 1'b1, HEX_LOWER);
        send_text("GPRMC,080000,", 1'b1, HEX_UPPER);
        send_text("GPRMC,080000,AV", 1'b1, HEX_UPPER);
        send_text("BDRMC,160000,A", 1'b1, HEX_UPPER);
        send_text("GPRMC,203040,A", 1'b0, HEX_UPPER);
        send_text("", 1'b1, HEX_UPPER);
        send_text(",,,,,,,,,,,,,,,,,,A,GGGGGGGGG", 1'b1, HEX_MIXED);
        send_raw("$GPRMC,99");
        send_text("GPRMC,010203,A", 1'b1, HEX_UPPER);
        send_raw("$GP,1,A*G");
        send_raw("$GP,1,A*4z");
        wait_idle();

        // Random sentences across several offsets, the extremes included.
        write_offset(5'd0);
        random_phase(230, 12);
        write_offset(5'd23);
        random_phase(230, 12);
        write_offset(5'd12);
        random_phase(230, 12);
        write_offset(HOUR_W'($urandom_range(0, 23)));
        random_phase(230, 12);

        if (error_count == 0 && expected_fixes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
